// File: sv/text_integer_parser_defines.svh
// Assertion macros used by the text integer parser top level
`ifndef TEXT_INTEGER_PARSER_DEFINES_SVH
`define TEXT_INTEGER_PARSER_DEFINES_SVH

// Check that cons holds in the same cycle as ante, outside reset
`define TIP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// Check that cons holds in the cycle after ante, outside reset
`define TIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

// File: sv/tip_pkg.sv
// Types, codes and character constants of the text integer parser
`timescale 1ns / 1ps

package tip_pkg;

    // Accumulator width; the value is kept modulo 2^VALUE_WIDTH (8 to 64)
    localparam int VALUE_WIDTH = 64;
    localparam int OUT_WIDTH   = 64;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3
    } t_phase;

    typedef enum logic [1:0] {
        RAD_AUTO = 2'd0,
        RAD_OCT  = 2'd1,
        RAD_DEC  = 2'd2,
        RAD_HEX  = 2'd3
    } t_radix;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
        logic [1:0] radix_mode;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] number_value;
        logic [7:0]           pushed_back_char;
        logic                 ended_at_eof;
        logic                 saw_digits;
    } t_out_beat;

    typedef struct packed {
        t_phase                 phase;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   neg;
        t_radix                 radix;
        logic                   seen;
    } t_parse_state;

endpackage

// File: sv/tip_step.sv
// Per-character parse step: next state and optional result beat
`timescale 1ns / 1ps

module tip_step (
    input  tip_pkg::t_in_beat     i_beat,
    input  tip_pkg::t_parse_state i_state,
    output tip_pkg::t_parse_state o_state,
    output logic                  o_emit,
    output tip_pkg::t_out_beat    o_result
);
    import tip_pkg::*;

    logic [7:0]             c;
    logic                   done;
    logic                   is_space;
    logic                   is_dec;
    logic                   is_upper;
    logic                   is_lower;
    logic [3:0]             dig;
    logic                   dig_ok;
    logic [VALUE_WIDTH-1:0] acc_scaled;
    logic [VALUE_WIDTH-1:0] val;
    t_parse_state           n;

    // Character classes
    always_comb begin
        c        = i_beat.character;
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        is_dec   = (c >= CH_ZERO) && (c <= CH_NINE);
        is_upper = (c >= CH_UA) && (c <= CH_UF);
        is_lower = (c >= CH_LA) && (c <= CH_LF);
    end

    // Walk the phases for this character
    always_comb begin
        n          = i_state;
        done       = 1'b0;
        o_emit     = 1'b0;
        o_result   = '0;
        dig        = '0;
        dig_ok     = 1'b0;
        acc_scaled = '0;
        val        = '0;

        if (i_beat.end_of_input) begin
            done = 1'b1;
            o_emit = 1'b1;
            o_result.ended_at_eof = 1'b1;
        end

        // Skip whitespace, latch radix and an optional sign
        if (!done && n.phase == PH_SPACE) begin
            if (is_space) begin
                done = 1'b1;
            end else begin
                n.radix = t_radix'(i_beat.radix_mode);
                n.phase = PH_SIGN;
                if (c == CH_PLUS || c == CH_MINUS) begin
                    n.neg = (c == CH_MINUS);
                    done = 1'b1;
                end
            end
        end

        // Look for a prefix zero in auto and hex modes
        if (!done && n.phase == PH_SIGN) begin
            if ((n.radix == RAD_AUTO || n.radix == RAD_HEX) && c == CH_ZERO) begin
                n.seen = 1'b1;
                n.phase = PH_ZERO;
                done = 1'b1;
            end else begin
                if (n.radix == RAD_AUTO) begin
                    n.radix = RAD_DEC;
                end
                n.phase = PH_DIGITS;
            end
        end

        // After a prefix zero: take an x as hex, else auto falls to octal
        if (!done && n.phase == PH_ZERO) begin
            n.phase = PH_DIGITS;
            if (c == CH_LX || c == CH_UX) begin
                n.radix = RAD_HEX;
                done = 1'b1;
            end else if (n.radix == RAD_AUTO) begin
                n.radix = RAD_OCT;
            end
        end

        // Digit decode for the active radix
        if (is_dec) begin
            dig = 4'(c - CH_ZERO);
            dig_ok = (n.radix != RAD_OCT) || (c <= CH_SEVEN);
        end else if (is_upper && n.radix == RAD_HEX) begin
            dig = 4'(c - CH_UA + 8'd10);
            dig_ok = 1'b1;
        end else if (is_lower && n.radix == RAD_HEX) begin
            dig = 4'(c - CH_LA + 8'd10);
            dig_ok = 1'b1;
        end

        // Scale the accumulator by the base with shifts
        unique case (n.radix)
            RAD_OCT: acc_scaled = n.acc << 3;
            RAD_HEX: acc_scaled = n.acc << 4;
            default: acc_scaled = (n.acc << 3) + (n.acc << 1);
        endcase

        // Accumulate a digit or end the number on anything else
        if (!done) begin
            if (dig_ok) begin
                n.acc = acc_scaled + VALUE_WIDTH'(dig);
                n.seen = 1'b1;
            end else begin
                o_emit = 1'b1;
                o_result.pushed_back_char = c;
            end
        end

        // Finish: sign the value and return to the start phase
        if (o_emit) begin
            val = n.neg ? VALUE_WIDTH'(~n.acc + 1'b1) : n.acc;
            o_result.number_value = OUT_WIDTH'(val);
            o_result.saw_digits = n.seen;
            n = '{phase: PH_SPACE, acc: '0, neg: 1'b0, radix: RAD_AUTO, seen: 1'b0};
        end

        o_state = n;
    end

endmodule

// File: sv/tip_out_buf.sv
// Result register with valid/stall towards the consumer
`timescale 1ns / 1ps

module tip_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  tip_pkg::t_out_beat i_data,
    output logic               o_ready,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tip_pkg::t_out_beat o_out_data
);
    import tip_pkg::*;

    logic      r_vld;
    logic      n_vld;
    t_out_beat r_data;

    // Free when empty or draining this cycle
    assign o_ready = !r_vld || !i_out_stall;

    always_comb begin
        n_vld = r_vld;
        if (i_load && o_ready) begin
            n_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Capture a new result beat
    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_data  = r_data;

endmodule

// File: sv/text_integer_parser.sv
// Text integer parser: one character beat in, one number beat out per number
// A terminating beat is held in the input register, then its result in the result register.
// Throughput: one character per cycle, unless a result beat waits on a stalled output.
// Stalls on the output back up through the result register to the input register.
// Reset (i_rst_n low, synchronous) empties both registers and returns to whitespace skip.
`timescale 1ns / 1ps

`include "text_integer_parser_defines.svh"

module text_integer_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tip_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tip_pkg::t_out_beat o_out_data
);
    import tip_pkg::*;

    logic         r_in_vld;
    logic         n_in_vld;
    t_in_beat     r_in;
    t_parse_state r_state;
    t_parse_state n_state;
    logic         emit;
    t_out_beat    result;
    logic         out_ready;
    logic         adv;

    tip_step u_step (
        .i_beat   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_emit   (emit),
        .o_result (result)
    );

    tip_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (adv && emit),
        .i_data      (result),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Advance the held beat unless its result has nowhere to go
    assign adv        = r_in_vld && (!emit || out_ready);
    assign o_in_stall = r_in_vld && !adv;

    always_comb begin
        n_in_vld = r_in_vld;
        if (i_in_valid && !o_in_stall) begin
            n_in_vld = 1'b1;
        end else if (adv) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Update parse state as each beat is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_SPACE, acc: '0, neg: 1'b0, radix: RAD_AUTO, seen: 1'b0};
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    `TIP_ASSERT_NEXT(a_emit_restarts, adv && emit, r_state.phase == PH_SPACE)
    `TIP_ASSERT_NOW(a_start_clear, r_state.phase == PH_SPACE || r_state.phase == PH_SIGN, !r_state.seen && r_state.acc == '0)
    `TIP_ASSERT_NEXT(a_held_beat, r_in_vld && !adv, r_in_vld && $stable(r_in) && $stable(r_state))

endmodule
